// ===== hw/rtl/fpbt_pkg.sv =====
// ============================================================================
// Free page bitmap tracker package
// Operation codes and default sizing for the page occupancy tracker.
// ============================================================================
package fpbt_pkg;

    // Default window size in pages and width of one bitmap word
    localparam int TRACKED_PAGES_DEF = 4096;
    localparam int WORD_BITS_DEF     = 32;

    // Operation codes carried on the input channel
    typedef enum logic [1:0] {
        OP_QUERY     = 2'd0,
        OP_MARK_OCC  = 2'd1,
        OP_MARK_FREE = 2'd2,
        OP_FIND      = 2'd3
    } t_op;

endpackage

// ===== hw/rtl/free_page_bitmap_tracker.sv =====
// ============================================================================
// Free page bitmap tracker
// Occupancy bitmap over a window of pages starting at a configurable base
// page id: query, mark occupied, mark free, and find the lowest free page.
// ============================================================================
//
//  channel  direction  handshake                  payload
//  -------  ---------  -------------------------  ------------------------------
//  in       sink       i_in_valid / o_in_stall    i_operation, i_page_number
//  out      source     o_out_valid / i_out_stall  o_is_occupied, o_found_free,
//                                                 o_free_page_number,
//                                                 o_outside_window
//  cfg      sink       i_cfg_we                   i_cfg_wdata (window base page)
//
//  Query, mark occupied and mark free step through S_DIV, S_ADDR and S_RMW:
//  divide the offset into a word index, read the bitmap word and form the bit
//  index, then modify and write it back (a query only samples the bit); a page
//  outside the window finishes in S_DIV and leaves the bitmap alone.
//  Find walks the bitmap one word per cycle through the single memory read
//  port, stops at the first word with a free page and returns its lowest free
//  page; when the window is full it returns no free page.
//  After reset the bitmap memory is swept to zero, one word per cycle; input
//  beats stall meanwhile, configuration writes are taken. One item is in
//  flight at a time; a finished result waits in the output register while the
//  next beat is accepted, and a new result holds until that register drains.
// ============================================================================
module free_page_bitmap_tracker
    import fpbt_pkg::*;
#(
    parameter int TRACKED_PAGES = TRACKED_PAGES_DEF,
    parameter int WORD_BITS     = WORD_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_operation,
    input  logic [31:0] i_page_number,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_is_occupied,
    output logic        o_found_free,
    output logic [31:0] o_free_page_number,
    output logic        o_outside_window
);

    // ------------------------------------------------------------------------
    // Sizing
    // ------------------------------------------------------------------------
    localparam int WORD_COUNT = (TRACKED_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int WIDX_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int CNT_W      = $clog2(WORD_COUNT + 1);
    localparam int OFF_W      = $clog2(TRACKED_PAGES);
    localparam int BIT_W      = $clog2(WORD_BITS);
    // word * WORD_BITS products, with headroom for WORD_BITS itself
    localparam int MUL_W      = OFF_W + 7;

    // Offset / WORD_BITS as multiply by reciprocal: with 2^(SHIFT-OFF_W) at
    // least WORD_BITS the truncated quotient is exact for any offset below
    // 2^OFF_W.
    localparam int SHIFT      = OFF_W + 7;
    localparam int RECIP_W    = SHIFT + 1;
    localparam int PROD_W     = OFF_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << SHIFT) / WORD_BITS) + 1);

    // Pages of the last word that are really tracked; the rest never read free
    localparam int LAST_BITS  = TRACKED_PAGES - (WORD_COUNT - 1) * WORD_BITS;
    localparam logic [WORD_BITS-1:0] LAST_MASK =
        {WORD_BITS{1'b1}} >> (WORD_BITS - LAST_BITS);

    localparam logic [WIDX_W-1:0] LAST_WORD = WIDX_W'(WORD_COUNT - 1);

    typedef enum logic [3:0] {
        S_CLEAR,  // sweep bitmap to zero after reset
        S_IDLE,   // take an input beat
        S_DIV,    // split offset into word index
        S_ADDR,   // read bitmap word, form bit index
        S_RMW,    // modify and write back, or sample for a query
        S_SCAN,   // walk words looking for a free bit
        S_ENC,    // encode lowest free bit
        S_SUM,    // add base to the free offset
        S_DONE    // hold result until the output register frees up
    } t_state;

    // ------------------------------------------------------------------------
    // Registers and next values
    // ------------------------------------------------------------------------
    t_state                 r_state, n_state;
    logic [31:0]            r_base;
    t_op                    r_op, n_op;
    logic [OFF_W-1:0]       r_offset, n_offset;
    logic                   r_outside, n_outside;
    logic [WIDX_W-1:0]      r_quot, n_quot;
    logic [BIT_W-1:0]       r_bit, n_bit;
    logic [WIDX_W-1:0]      r_clr_idx, n_clr_idx;
    logic [CNT_W-1:0]       r_scan, n_scan;
    logic                   r_chk_vld, n_chk_vld;
    logic [WIDX_W-1:0]      r_chk_idx, n_chk_idx;
    logic [WIDX_W-1:0]      r_wsel, n_wsel;
    logic [WORD_BITS-1:0]   r_free_bits, n_free_bits;
    logic [OFF_W-1:0]       r_word_off, n_word_off;

    // result held while the output register is busy
    logic                   r_res_occ, n_res_occ;
    logic                   r_res_found, n_res_found;
    logic [31:0]            r_res_page, n_res_page;
    logic                   r_res_out, n_res_out;

    // output register
    logic                   r_out_valid, n_out_valid;
    logic                   r_occ, n_occ;
    logic                   r_found_free, n_found_free;
    logic [31:0]            r_free_page, n_free_page;
    logic                   r_out_win, n_out_win;

    // bitmap memory
    logic [WORD_BITS-1:0]   mem [WORD_COUNT];
    logic [WORD_BITS-1:0]   r_rd_data;
    logic [WIDX_W-1:0]      w_raddr;
    logic [WIDX_W-1:0]      w_waddr;
    logic [WORD_BITS-1:0]   w_wdata;
    logic                   w_mem_we;

    // datapath helpers
    logic                   w_accept;
    logic                   w_out_free;
    logic [31:0]            w_offset32;
    logic [PROD_W-1:0]      w_prod;
    logic [MUL_W-1:0]       w_quot_x_bits;
    logic [MUL_W-1:0]       w_wsel_x_bits;
    logic [WORD_BITS-1:0]   w_bit_mask;
    logic [WORD_BITS-1:0]   w_chk_free;
    logic [BIT_W-1:0]       w_first_free;

    // finishing an item
    logic                   w_fin;
    logic                   w_fin_occ;
    logic                   w_fin_found;
    logic [31:0]            w_fin_page;
    logic                   w_fin_out;

    assign o_in_stall         = (r_state != S_IDLE);
    assign w_accept           = i_in_valid && !o_in_stall;
    assign w_out_free         = !r_out_valid || !i_out_stall;

    assign o_out_valid        = r_out_valid;
    assign o_is_occupied      = r_occ;
    assign o_found_free       = r_found_free;
    assign o_free_page_number = r_free_page;
    assign o_outside_window   = r_out_win;

    // Offset from the window base wraps, so pages below the base fall outside
    assign w_offset32    = i_page_number - r_base;
    assign w_prod        = PROD_W'(r_offset) * PROD_W'(RECIP);
    assign w_quot_x_bits = MUL_W'(r_quot) * MUL_W'(WORD_BITS);
    assign w_wsel_x_bits = MUL_W'(r_wsel) * MUL_W'(WORD_BITS);
    assign w_bit_mask    = WORD_BITS'(1) << r_bit;

    // Free pages of the word now on the read port; clip the partial last word
    assign w_chk_free = ~r_rd_data & ((r_chk_idx == LAST_WORD) ? LAST_MASK
                                                               : {WORD_BITS{1'b1}});

    // Lowest set bit of the captured free bits
    always_comb begin
        w_first_free = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (r_free_bits[i]) begin
                w_first_free = BIT_W'(i);
            end
        end
    end

    // Memory port selection
    always_comb begin
        w_raddr = r_quot;
        if (r_state == S_SCAN) begin
            w_raddr = (r_scan < CNT_W'(WORD_COUNT)) ? r_scan[WIDX_W-1:0] : '0;
        end
    end

    assign w_mem_we = (r_state == S_CLEAR) ||
                      ((r_state == S_RMW) && (r_op == OP_MARK_OCC || r_op == OP_MARK_FREE));
    assign w_waddr  = (r_state == S_CLEAR) ? r_clr_idx : r_quot;
    always_comb begin
        w_wdata = '0;
        if (r_state == S_RMW) begin
            w_wdata = (r_op == OP_MARK_OCC) ? (r_rd_data | w_bit_mask)
                                            : (r_rd_data & ~w_bit_mask);
        end
    end

    // ------------------------------------------------------------------------
    // Next-state logic
    // ------------------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_offset    = r_offset;
        n_outside   = r_outside;
        n_quot      = r_quot;
        n_bit       = r_bit;
        n_clr_idx   = r_clr_idx;
        n_scan      = r_scan;
        n_chk_vld   = r_chk_vld;
        n_chk_idx   = r_chk_idx;
        n_wsel      = r_wsel;
        n_free_bits = r_free_bits;
        n_word_off  = r_word_off;
        n_res_occ   = r_res_occ;
        n_res_found = r_res_found;
        n_res_page  = r_res_page;
        n_res_out   = r_res_out;
        n_out_valid = r_out_valid && i_out_stall;
        n_occ       = r_occ;
        n_found_free = r_found_free;
        n_free_page = r_free_page;
        n_out_win   = r_out_win;

        w_fin       = 1'b0;
        w_fin_occ   = 1'b0;
        w_fin_found = 1'b0;
        w_fin_page  = '0;
        w_fin_out   = 1'b0;

        case (r_state)
            S_CLEAR: begin
                n_clr_idx = r_clr_idx + 1'b1;
                if (r_clr_idx == LAST_WORD) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_op      = t_op'(i_operation);
                    n_offset  = w_offset32[OFF_W-1:0];
                    n_outside = (w_offset32 >= 32'(TRACKED_PAGES));
                    n_scan    = '0;
                    n_chk_vld = 1'b0;
                    n_state   = (t_op'(i_operation) == OP_FIND) ? S_SCAN : S_DIV;
                end
            end
            S_DIV: begin
                n_quot = w_prod[SHIFT +: WIDX_W];
                if (r_outside) begin
                    // out of window: flag it, leave the bitmap alone
                    w_fin     = 1'b1;
                    w_fin_out = 1'b1;
                end else begin
                    n_state = S_ADDR;
                end
            end
            S_ADDR: begin
                n_bit   = BIT_W'(MUL_W'(r_offset) - w_quot_x_bits);
                n_state = S_RMW;
            end
            S_RMW: begin
                w_fin     = 1'b1;
                w_fin_occ = (r_op == OP_QUERY) && r_rd_data[r_bit];
            end
            S_SCAN: begin
                n_chk_vld = (r_scan < CNT_W'(WORD_COUNT));
                n_chk_idx = r_scan[WIDX_W-1:0];
                if (r_scan < CNT_W'(WORD_COUNT)) begin
                    n_scan = r_scan + 1'b1;
                end
                if (r_chk_vld && (|w_chk_free)) begin
                    n_wsel      = r_chk_idx;
                    n_free_bits = w_chk_free;
                    n_state     = S_ENC;
                end else if (r_chk_vld && (r_chk_idx == LAST_WORD)) begin
                    // window full
                    w_fin = 1'b1;
                end
            end
            S_ENC: begin
                n_bit      = w_first_free;
                n_word_off = OFF_W'(w_wsel_x_bits);
                n_state    = S_SUM;
            end
            S_SUM: begin
                w_fin       = 1'b1;
                w_fin_found = 1'b1;
                w_fin_page  = r_base + 32'(r_word_off) + 32'(r_bit);
            end
            S_DONE: begin
                w_fin       = 1'b1;
                w_fin_occ   = r_res_occ;
                w_fin_found = r_res_found;
                w_fin_page  = r_res_page;
                w_fin_out   = r_res_out;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Hand the result to the output register, or park it until it drains
        if (w_fin) begin
            n_res_occ   = w_fin_occ;
            n_res_found = w_fin_found;
            n_res_page  = w_fin_page;
            n_res_out   = w_fin_out;
            if (w_out_free) begin
                n_out_valid  = 1'b1;
                n_occ        = w_fin_occ;
                n_found_free = w_fin_found;
                n_free_page  = w_fin_page;
                n_out_win    = w_fin_out;
                n_state      = S_IDLE;
            end else begin
                n_state = S_DONE;
            end
        end
    end

    // ------------------------------------------------------------------------
    // State and registered outputs
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
            r_chk_vld   <= 1'b0;
            r_base      <= '0;
        end else begin
            r_state     <= n_state;
            r_clr_idx   <= n_clr_idx;
            r_out_valid <= n_out_valid;
            r_chk_vld   <= n_chk_vld;
            if (i_cfg_we) begin
                r_base <= i_cfg_wdata;
            end
        end
        r_op         <= n_op;
        r_offset     <= n_offset;
        r_outside    <= n_outside;
        r_quot       <= n_quot;
        r_bit        <= n_bit;
        r_scan       <= n_scan;
        r_chk_idx    <= n_chk_idx;
        r_wsel       <= n_wsel;
        r_free_bits  <= n_free_bits;
        r_word_off   <= n_word_off;
        r_res_occ    <= n_res_occ;
        r_res_found  <= n_res_found;
        r_res_page   <= n_res_page;
        r_res_out    <= n_res_out;
        r_occ        <= n_occ;
        r_found_free <= n_found_free;
        r_free_page  <= n_free_page;
        r_out_win    <= n_out_win;
    end

    // ------------------------------------------------------------------------
    // Bitmap memory: one write, one registered read. A write in S_RMW always
    // lands before the next item can issue its read, so no forwarding.
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            mem[w_waddr] <= w_wdata;
        end
        r_rd_data <= mem[w_raddr];
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_mem_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem_we |-> (r_state == S_CLEAR || r_state == S_RMW))
        else $error("bitmap written outside clear sweep or read-modify-write");

    a_rmw_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RMW) |-> ($past(r_state) == S_ADDR))
        else $error("read-modify-write without a preceding word read");

    a_found_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_found_free) |-> (!r_out_win && !r_occ))
        else $error("find result carries query or window flags");

    a_free_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SUM) |->
            ((32'(r_word_off) + 32'(r_bit)) < 32'(TRACKED_PAGES)))
        else $error("free page offset beyond tracked window");

endmodule

// ===== verif/free_page_bitmap_tracker_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Free page bitmap tracker testbench
// Drives query, mark and find beats into the tracker under several window
// bases, predicts every result from a private occupancy bitmap and checks
// each result beat field by field, with random idling on both channels.
// ============================================================================
module testbench;
    import fpbt_pkg::*;

    // Window size of the block as instantiated with its defaults
    localparam int TRACKED    = TRACKED_PAGES_DEF;
    localparam int WORD_COUNT = (TRACKED_PAGES_DEF + WORD_BITS_DEF - 1) / WORD_BITS_DEF;
    // Cycles without a beat, while work is outstanding, before giving up
    localparam int QUIET_LIMIT = 4000;
    // Pages marked at the bottom of the window before the deep finds
    localparam int FILL_PAGES  = 256;

    typedef struct {
        t_op         op;
        logic [31:0] page;
    } t_page_req;

    typedef struct {
        logic        occupied;
        logic        found;
        logic [31:0] free_page;
        logic        outside;
    } t_page_resp;

    // How a side idles between beats during one phase
    typedef enum int {
        IDLE_NONE,
        IDLE_SPARSE,
        IDLE_FULL
    } t_idle_mode;

    logic        i_clk     = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [31:0] cfg_wdata = '0;
    logic        in_valid  = 1'b0;
    t_op         in_op     = OP_QUERY;
    logic [31:0] in_page   = '0;
    logic        out_stall = 1'b0;

    logic        in_stall;
    logic        out_valid;
    logic        out_occupied;
    logic        out_found;
    logic [31:0] out_free_page;
    logic        out_outside;

    // Private copy of the block state: one bit per tracked page offset
    bit [TRACKED-1:0] occ_map;
    logic [31:0]      base_page;

    t_page_req  pending_ops[$];
    t_page_resp expected_results[$];
    t_page_req  cur_req;
    bit         req_busy;
    int         gap_left;
    int         stall_left;
    t_idle_mode tx_idle = IDLE_NONE;
    t_idle_mode rx_idle = IDLE_NONE;
    int         error_count;
    int         quiet_cycles;

    free_page_bitmap_tracker i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (rst_n),
        .i_cfg_we           (cfg_we),
        .i_cfg_wdata        (cfg_wdata),
        .i_in_valid         (in_valid),
        .o_in_stall         (in_stall),
        .i_operation        (in_op),
        .i_page_number      (in_page),
        .o_out_valid        (out_valid),
        .i_out_stall        (out_stall),
        .o_is_occupied      (out_occupied),
        .o_found_free       (out_found),
        .o_free_page_number (out_free_page),
        .o_outside_window   (out_outside)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predict one operation and update the private bitmap.
    // Pages below the base wrap to a large offset and so fall outside.
    function automatic t_page_resp apply_page_op(t_page_req req);
        t_page_resp  r;
        logic [31:0] offset;
        r      = '{occupied: 1'b0, found: 1'b0, free_page: '0, outside: 1'b0};
        offset = req.page - base_page;
        if (req.op == OP_FIND) begin
            // Scan for the lowest free offset; the sum wraps modulo 2^32
            for (int i = 0; i < TRACKED && !r.found; i++) begin
                if (!occ_map[i]) begin
                    r.found     = 1'b1;
                    r.free_page = base_page + i;
                end
            end
        end else if (offset >= TRACKED) begin
            // Out-of-window marks leave the bitmap alone
            r.outside = 1'b1;
        end else begin
            case (req.op)
                OP_QUERY:    r.occupied = occ_map[offset];
                OP_MARK_OCC: occ_map[offset] = 1'b1;
                default:     occ_map[offset] = 1'b0;
            endcase
        end
        return r;
    endfunction

    // Draw the idle cycles that one side spends before its next beat
    function automatic int draw_wait(t_idle_mode mode);
        case (mode)
            IDLE_NONE:   return 0;
            IDLE_SPARSE: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
            default:     return $urandom_range(0, 17);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Request driver: hold each beat until accepted, predict it on acceptance,
    // then idle for the drawn gap before launching the next queued request.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            req_busy = 1'b0;
            gap_left = 0;
        end else begin
            if (req_busy && !in_stall) begin
                expected_results.push_back(apply_page_op(cur_req));
                req_busy = 1'b0;
                gap_left = draw_wait(tx_idle);
            end
            if (!req_busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_ops.size() != 0) begin
                    cur_req  = pending_ops.pop_front();
                    req_busy = 1'b1;
                end
            end
            // Single assignment per edge keeps valid high across back-to-back beats
            in_valid <= req_busy;
            in_op    <= cur_req.op;
            in_page  <= cur_req.page;
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: check every accepted result beat against the oldest
    // prediction, then stall the channel for the drawn number of cycles.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_page_resp want;
        if (!rst_n) begin
            out_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (out_valid && !out_stall) begin
                if (expected_results.size() == 0) begin
                    $error("result beat with no request outstanding");
                    error_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (out_occupied !== want.occupied) begin
                        $error("is_occupied: expected %0h, got %0h",
                               want.occupied, out_occupied);
                        error_count++;
                    end
                    if (out_found !== want.found) begin
                        $error("found_free: expected %0h, got %0h",
                               want.found, out_found);
                        error_count++;
                    end
                    if (out_free_page !== want.free_page) begin
                        $error("free_page_number: expected %08h, got %08h",
                               want.free_page, out_free_page);
                        error_count++;
                    end
                    if (out_outside !== want.outside) begin
                        $error("outside_window: expected %0h, got %0h",
                               want.outside, out_outside);
                        error_count++;
                    end
                end
                stall_left = draw_wait(rx_idle);
            end else if (stall_left > 0) begin
                stall_left--;
            end
            out_stall <= (stall_left != 0);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: count cycles without any beat while work is outstanding.
    // The reset sweep and the longest find scan stay far below the limit.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
            (pending_ops.size() == 0 && !req_busy && expected_results.size() == 0)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("testbench NOT OK");
                $finish;
            end
        end
    end

    task automatic add_req(input t_op op, input logic [31:0] page);
        t_page_req req;
        req.op   = op;
        req.page = page;
        pending_ops.push_back(req);
    endtask

    // Wait until every queued request is accepted and every result is back
    task automatic drain_all();
        while (pending_ops.size() != 0 || req_busy || expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    // Write the window base only with the block idle
    task automatic write_base(input logic [31:0] value);
        drain_all();
        repeat (8) @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        base_page = value;
    endtask

    // Random phase: mostly in-window traffic inside a hot range of offsets,
    // with runs of consecutive marks so that finds land at varied depths,
    // plus a share of out-of-window and below-base noise.
    task automatic run_random_phase(input logic [31:0] base, input int count,
                                    input int hot, input int occ_pct);
        int          made;
        int          pick;
        int          run_len;
        t_op         run_op;
        logic [31:0] off;
        logic [31:0] noise_page;
        write_base(base);
        tx_idle = t_idle_mode'($urandom_range(0, 2));
        rx_idle = t_idle_mode'($urandom_range(0, 2));
        made = 0;
        while (made < count) begin
            pick = $urandom_range(0, 99);
            off  = $urandom_range(0, hot);
            if (pick < 8) begin
                run_len = $urandom_range(8, 48);
                run_op  = ($urandom_range(0, 99) < occ_pct) ? OP_MARK_OCC : OP_MARK_FREE;
                for (int k = 0; k < run_len; k++)
                    add_req(run_op, base + ((off + k) & (TRACKED - 1)));
                made += run_len;
            end else begin
                if (pick < 16) begin
                    case ($urandom_range(0, 2))
                        0:       noise_page = $urandom;
                        1:       noise_page = base - $urandom_range(1, 16);
                        default: noise_page = base + TRACKED + $urandom_range(0, 16);
                    endcase
                    add_req(t_op'($urandom_range(0, 3)), noise_page);
                end else if (pick < 30) begin
                    add_req(OP_FIND, $urandom);
                end else if (pick < 50) begin
                    add_req(OP_QUERY, base + off);
                end else if (pick < 50 + occ_pct / 2) begin
                    add_req(OP_MARK_OCC, base + off);
                end else begin
                    add_req(OP_MARK_FREE, base + off);
                end
                made++;
            end
        end
    endtask

    initial begin
        occ_map     = '0;
        base_page   = '0;
        error_count = 0;
        repeat (6) @(posedge i_clk);
        rst_n <= 1'b1;

        // Directed: reset base, edges of the window, outside pages, finds
        tx_idle = IDLE_SPARSE;
        rx_idle = IDLE_SPARSE;
        add_req(OP_QUERY,     32'h0000_0000);
        add_req(OP_MARK_OCC,  32'h0000_0000);
        add_req(OP_QUERY,     32'h0000_0000);
        add_req(OP_FIND,      32'hFFFF_FFFF);
        add_req(OP_MARK_OCC,  TRACKED - 1);
        add_req(OP_QUERY,     TRACKED - 1);
        add_req(OP_MARK_OCC,  TRACKED);
        add_req(OP_QUERY,     TRACKED);
        add_req(OP_QUERY,     32'hFFFF_FFFF);
        add_req(OP_MARK_FREE, 32'hFFFF_FFFF);
        add_req(OP_MARK_FREE, 32'h0000_0000);
        add_req(OP_FIND,      32'h0000_0000);
        add_req(OP_QUERY,     32'h8000_0000);
        add_req(OP_MARK_OCC,  32'h0000_0001);
        add_req(OP_MARK_OCC,  32'h0000_0000);
        add_req(OP_FIND,      32'h5555_AAAA);
        add_req(OP_MARK_FREE, 32'h0000_0001);
        add_req(OP_QUERY,     32'h0000_0001);

        // Directed: top base, so pages below it and find sums wrap
        write_base(32'hFFFF_FFFF);
        add_req(OP_QUERY,     32'hFFFF_FFFE);
        add_req(OP_MARK_OCC,  32'hFFFF_FFFF);
        add_req(OP_FIND,      32'h0000_0000);
        add_req(OP_QUERY,     32'h0000_0000);
        add_req(OP_QUERY,     TRACKED - 2);
        add_req(OP_QUERY,     TRACKED - 1);
        add_req(OP_MARK_OCC,  32'h0000_0000);
        add_req(OP_FIND,      32'h0000_0000);
        add_req(OP_MARK_FREE, 32'hFFFF_FFFF);

        // Fill the low words of the window, straddling 2^32, then find deep in it
        write_base(32'hFFFF_FF80);
        tx_idle = IDLE_NONE;
        rx_idle = IDLE_NONE;
        for (int k = 0; k < FILL_PAGES; k++)
            add_req(OP_MARK_OCC, base_page + k);
        add_req(OP_FIND,      32'h0000_0000);
        add_req(OP_QUERY,     base_page + 100);
        add_req(OP_MARK_FREE, 32'h0000_0010);
        add_req(OP_FIND,      32'h0000_0000);
        add_req(OP_MARK_OCC,  32'h0000_0010);
        add_req(OP_FIND,      32'h0000_0000);
        add_req(OP_MARK_FREE, 32'hFFFF_FF80);
        add_req(OP_FIND,      32'h0000_0000);

        // Random phases across bases, hot ranges and mark balance
        run_random_phase(32'h0000_0000, 160, TRACKED - 1, 30);
        run_random_phase(32'hFFFF_FFFF, 160, 255, 80);
        run_random_phase($urandom,      160, TRACKED - 1, 70);
        run_random_phase(32'h7FFF_F800, 160, 31, 50);
        run_random_phase($urandom,      160, 1023, 85);
        run_random_phase(32'hFFFF_F000, 160, TRACKED - 1, 60);

        // Let any stray result beat show up before the verdict
        drain_all();
        repeat (WORD_COUNT + 16) @(posedge i_clk);
        if (error_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
